// ----- rtl/core/bitplane_pixel_plot_cache_top_assert.svh -----
// Assertion macros used by the plotter sequencer module bpc_seq.
// Each macro expects clk and rst_n in scope.
`ifndef BITPLANE_PIXEL_PLOT_CACHE_TOP_ASSERT_SVH
`define BITPLANE_PIXEL_PLOT_CACHE_TOP_ASSERT_SVH

`define BPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

`define BPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

// ----- rtl/core/bpc_pkg.sv -----
package bpc_pkg;

  localparam int ADDR_W = 20;

  localparam logic [2:0] ACT_SET_COLOR  = 3'd0;
  localparam logic [2:0] ACT_PLOT       = 3'd1;
  localparam logic [2:0] ACT_READ_PIXEL = 3'd2;
  localparam logic [2:0] ACT_FLUSH      = 3'd3;
  localparam logic [2:0] ACT_RAM_WRITE  = 3'd4;
  localparam logic [2:0] ACT_RAM_READ   = 3'd5;

  localparam logic [2:0] REG_DRAW_TRANSPARENT = 3'd0;
  localparam logic [2:0] REG_DITHER_ENABLE    = 3'd1;
  localparam logic [2:0] REG_HIGH_NIBBLE      = 3'd2;
  localparam logic [2:0] REG_FREEZE_HIGH      = 3'd3;
  localparam logic [2:0] REG_OBJECT_LAYOUT    = 3'd4;
  localparam logic [2:0] REG_COLOR_MODE       = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT    = 3'd6;
  localparam logic [2:0] REG_SCREEN_BASE      = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  color_source;
    logic [16:0] ram_address;
    logic [7:0]  ram_data;
  } bpc_in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       read_valid;
  } bpc_out_t;

  typedef struct packed {
    logic       draw_transparent;
    logic       dither_enable;
    logic       high_nibble_mode;
    logic       freeze_high_mode;
    logic       object_layout;
    logic [1:0] color_mode;
    logic [1:0] screen_height;
    logic [7:0] screen_base;
  } bpc_cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PLOT, S_PLOT_WR, S_FLUSH, S_FLUSH2, S_PIX, S_ADDR,
    S_MOD, S_RD, S_WR, S_DATA, S_HWR, S_COPY, S_DONE
  } bpc_state_t;

  typedef enum logic [1:0] {M_FLUSH, M_PIX, M_HWR, M_HRD} bpc_mode_t;

  function automatic logic [ADDR_W-1:0] row_address(
    input logic [7:0] x, input logic [7:0] y, input bpc_cfg_t cfg);
    logic [1:0]        sel;
    logic [9:0]        cn;
    logic [ADDR_W-1:0] scaled;
    sel = cfg.object_layout ? 2'd3 : cfg.screen_height;
    case (sel)
      2'd0: cn = {1'b0, x[7:3], 4'b0} + 10'(y[7:3]);
      2'd1: cn = {1'b0, x[7:3], 4'b0} + {3'b0, x[7:3], 2'b0} + 10'(y[7:3]);
      2'd2: cn = {1'b0, x[7:3], 4'b0} + {2'b0, x[7:3], 3'b0} + 10'(y[7:3]);
      default: cn = {y[7], x[7], y[6:3], x[6:3]};
    endcase
    case (cfg.color_mode)
      2'd0: scaled = ADDR_W'({cn, 4'b0});
      2'd3: scaled = ADDR_W'({cn, 6'b0});
      default: scaled = ADDR_W'({cn, 5'b0});
    endcase
    return scaled + ADDR_W'({cfg.screen_base, 10'b0}) + ADDR_W'({y[2:0], 1'b0});
  endfunction

  function automatic logic [ADDR_W-1:0] plane_offset(input logic [2:0] n);
    return ADDR_W'({n[2:1], 3'b0, n[0]});
  endfunction

endpackage

// ----- rtl/core/bitplane_pixel_plot_cache_top.sv -----
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_stall    | bpc_in_t  (action, position, color, ram)
// out_     | output    | out_valid / out_stall  | bpc_out_t (read_value, read_valid)
// cfg_     | input     | cfg_valid / cfg_ready  | cfg_index (3 bits), cfg_data (8 bits)
//
// After reset the RAM is cleared one byte per cycle, all RAM_BYTES of it, before any item is taken.
// Each item runs through one sequencer and a shared address reduce unit on a single-port RAM.
// A plane access is one write for a full line and a read then a write for a partial one, after
// any address wrap steps, so an eviction writes back up to eight planes.
// Set color and a skipped plot touch no RAM, a host write is a single write and a host read a single read;
// read pixel can evict twice and then read up to eight planes.
// A finished result waits in the output register while the next item is accepted.
module bitplane_pixel_plot_cache_top
  import bpc_pkg::*;
#(
  parameter int RAM_BYTES = 131072
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  bpc_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output bpc_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  bpc_cfg_t cfg_r, cfg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DRAW_TRANSPARENT: cfg_nxt.draw_transparent = cfg_data[0];
        REG_DITHER_ENABLE:    cfg_nxt.dither_enable    = cfg_data[0];
        REG_HIGH_NIBBLE:      cfg_nxt.high_nibble_mode = cfg_data[0];
        REG_FREEZE_HIGH:      cfg_nxt.freeze_high_mode = cfg_data[0];
        REG_OBJECT_LAYOUT:    cfg_nxt.object_layout    = cfg_data[0];
        REG_COLOR_MODE:       cfg_nxt.color_mode       = cfg_data[1:0];
        REG_SCREEN_HEIGHT:    cfg_nxt.screen_height    = cfg_data[1:0];
        REG_SCREEN_BASE:      cfg_nxt.screen_base      = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  bpc_seq #(.RAM_BYTES(RAM_BYTES)) u_seq (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ----- rtl/core/bpc_ram.sv -----
module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/bpc_seq.sv -----
`include "bitplane_pixel_plot_cache_top_assert.svh"

module bpc_seq
  import bpc_pkg::*;
#(
  parameter int RAM_BYTES = 131072
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bpc_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  bpc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bpc_out_t out_data
);

  localparam int AW = $clog2(RAM_BYTES);
  localparam logic [ADDR_W-1:0] RAM_SIZE = ADDR_W'(RAM_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(RAM_BYTES - 1);

  bpc_state_t state_r, state_nxt, ret_r, ret_nxt;
  bpc_mode_t  mode_r, mode_nxt;
  bpc_in_t    item_r, item_nxt;
  logic [7:0] color_r, color_nxt;
  logic [7:0] new_pix_r [8];
  logic [7:0] new_pix_nxt [8];
  logic [7:0] old_pix_r [8];
  logic [7:0] old_pix_nxt [8];
  logic [7:0] new_pend_r, new_pend_nxt, old_pend_r, old_pend_nxt;
  logic [12:0] new_span_r, new_span_nxt, old_span_r, old_span_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt, addr_r, addr_nxt;
  logic [2:0] n_r, n_nxt;
  logic [7:0] acc_r, acc_nxt, res_r, res_nxt;
  logic res_vld_r, res_vld_nxt;
  logic out_valid_r, out_valid_nxt;
  bpc_out_t out_data_r, out_data_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic ram_en, ram_we;
  logic [7:0] ram_wdata, ram_rdata;
  logic [AW-1:0] ram_addr;

  logic [2:0] planes_m1;
  logic skip;
  logic [7:0] pc;
  logic [12:0] span;
  logic [2:0] idx;
  logic [7:0] pdata, merged, pend_upd;
  logic [2:0] pbit;

  bpc_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_ram (
    .clk(clk), .en(ram_en), .we(ram_we), .addr(ram_addr),
    .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= S_DONE;
      mode_r      <= M_FLUSH;
      color_r     <= '0;
      new_pend_r  <= '0;
      old_pend_r  <= '0;
      new_span_r  <= '0;
      old_span_r  <= '0;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      mode_r      <= mode_nxt;
      color_r     <= color_nxt;
      new_pend_r  <= new_pend_nxt;
      old_pend_r  <= old_pend_nxt;
      new_span_r  <= new_span_nxt;
      old_span_r  <= old_span_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    new_pix_r  <= new_pix_nxt;
    old_pix_r  <= old_pix_nxt;
    base_r     <= base_nxt;
    addr_r     <= addr_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    res_vld_r  <= res_vld_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    case (cfg.color_mode)
      2'd0: planes_m1 = 3'd1;
      2'd3: planes_m1 = 3'd7;
      default: planes_m1 = 3'd3;
    endcase
    if (cfg.color_mode == 2'd3) begin
      skip = !cfg.draw_transparent &&
             (cfg.freeze_high_mode ? (color_r[3:0] == 4'd0) : (color_r == 8'd0));
    end else begin
      skip = !cfg.draw_transparent && (color_r[3:0] == 4'd0);
    end
    pc = color_r;
    if (cfg.dither_enable && cfg.color_mode != 2'd3) begin
      pc = {4'b0, (item_r.pos_x[0] ^ item_r.pos_y[0]) ? color_r[7:4] : color_r[3:0]};
    end
    span = {item_r.pos_y, item_r.pos_x[7:3]};
    idx = ~item_r.pos_x[2:0];
    pbit = ~item_r.pos_x[2:0];
    for (int i = 0; i < 8; i++) begin
      pdata[i] = old_pix_r[i][n_r];
    end
    merged = (old_pend_r == 8'hff) ? pdata :
             ((pdata & old_pend_r) | (ram_rdata & ~old_pend_r));
    pend_upd = new_pend_r | (8'd1 << idx);
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mode_nxt      = mode_r;
    item_nxt      = item_r;
    color_nxt     = color_r;
    new_pix_nxt   = new_pix_r;
    old_pix_nxt   = old_pix_r;
    new_pend_nxt  = new_pend_r;
    old_pend_nxt  = old_pend_r;
    new_span_nxt  = new_span_r;
    old_span_nxt  = old_span_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    res_vld_nxt   = res_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    clr_nxt       = clr_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = addr_r[AW-1:0];
    ram_wdata     = merged;
    in_stall      = (state_r != S_IDLE);

    unique case (state_r)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = AW'(clr_r + 1'b1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          res_nxt     = '0;
          res_vld_nxt = 1'b0;
          addr_nxt    = ADDR_W'(in_data.ram_address);
          case (in_data.action)
            ACT_SET_COLOR: begin
              if (cfg.high_nibble_mode) begin
                color_nxt = {color_r[7:4], in_data.color_source[7:4]};
              end else if (cfg.freeze_high_mode) begin
                color_nxt = {color_r[7:4], in_data.color_source[3:0]};
              end else begin
                color_nxt = in_data.color_source;
              end
              state_nxt = S_DONE;
            end
            ACT_PLOT: state_nxt = S_PLOT;
            ACT_READ_PIXEL, ACT_FLUSH: begin
              ret_nxt   = S_FLUSH2;
              state_nxt = S_FLUSH;
            end
            ACT_RAM_WRITE: begin
              mode_nxt  = M_HWR;
              state_nxt = S_MOD;
            end
            ACT_RAM_READ: begin
              mode_nxt  = M_HRD;
              state_nxt = S_MOD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PLOT: begin
        if (skip) begin
          state_nxt = S_DONE;
        end else if (span != new_span_r) begin
          ret_nxt   = S_PLOT_WR;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_PLOT_WR;
        end
      end
      S_PLOT_WR: begin
        new_span_nxt     = span;
        new_pix_nxt[idx] = pc;
        new_pend_nxt     = pend_upd;
        if (pend_upd == 8'hff) begin
          ret_nxt   = S_DONE;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FLUSH: begin
        mode_nxt = M_FLUSH;
        n_nxt    = '0;
        base_nxt = row_address({old_span_r[4:0], 3'b0}, old_span_r[12:5], cfg);
        state_nxt = (old_pend_r == 8'd0) ? S_COPY : S_ADDR;
      end
      S_FLUSH2: begin
        ret_nxt   = (item_r.action == ACT_READ_PIXEL) ? S_PIX : S_DONE;
        state_nxt = S_FLUSH;
      end
      S_PIX: begin
        mode_nxt  = M_PIX;
        n_nxt     = '0;
        acc_nxt   = '0;
        base_nxt  = row_address(item_r.pos_x, item_r.pos_y, cfg);
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        addr_nxt  = base_r + plane_offset(n_r);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (addr_r >= RAM_SIZE) begin
          addr_nxt = addr_r - RAM_SIZE;
        end else begin
          case (mode_r)
            M_FLUSH: state_nxt = (old_pend_r == 8'hff) ? S_WR : S_RD;
            M_HWR:   state_nxt = S_HWR;
            default: state_nxt = S_RD;
          endcase
        end
      end
      S_RD: begin
        ram_en    = 1'b1;
        state_nxt = (mode_r == M_FLUSH) ? S_WR : S_DATA;
      end
      S_WR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (n_r == planes_m1) begin
          state_nxt = S_COPY;
        end else begin
          n_nxt     = 3'(n_r + 1'b1);
          state_nxt = S_ADDR;
        end
      end
      S_DATA: begin
        if (mode_r == M_PIX) begin
          acc_nxt = acc_r | (8'(ram_rdata[pbit]) << n_r);
          if (n_r == planes_m1) begin
            res_nxt     = acc_nxt;
            res_vld_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            n_nxt     = 3'(n_r + 1'b1);
            state_nxt = S_ADDR;
          end
        end else begin
          res_nxt     = ram_rdata;
          res_vld_nxt = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_HWR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = item_r.ram_data;
        state_nxt = S_DONE;
      end
      S_COPY: begin
        old_pix_nxt  = new_pix_r;
        old_pend_nxt = new_pend_r;
        old_span_nxt = new_span_r;
        new_pend_nxt = '0;
        state_nxt    = ret_r;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = res_r;
          out_data_nxt.read_valid = res_vld_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BPC_ASSERT_IMP(a_ram_in_range, ram_en && state_r != S_CLEAR, addr_r < RAM_SIZE)
  `BPC_ASSERT_IMP(a_plane_bound, (state_r == S_WR || state_r == S_DATA) && mode_r != M_HRD, n_r <= planes_m1)
  `BPC_ASSERT_NXT(a_copy_clears, state_r == S_COPY, new_pend_r == 8'd0)

endmodule

// ----- tb/sv/bitplane_pixel_plot_cache_checker.sv -----
`timescale 1ns / 1ps

module bitplane_pixel_plot_cache_checker
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  bpc_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  bpc_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         results_due,
  output int         pixel_reads
);

  localparam int MEM_BYTES = 131072;
  localparam int OLDER = 0;
  localparam int NEWER = 1;

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  color_reg;
  logic [7:0]  line_pix [2][8];
  logic [7:0]  line_pend [2];
  logic [12:0] line_span [2];
  bpc_cfg_t    cfg;
  bpc_out_t    due_q [$];

  function automatic int unsigned plane_total();
    return 2 << (cfg.color_mode - (cfg.color_mode >> 1));
  endfunction

  function automatic int unsigned row_base(int unsigned x, int unsigned y);
    int unsigned sel;
    int unsigned cn;
    sel = cfg.object_layout ? 3 : cfg.screen_height;
    case (sel)
      0: cn = ((x & 'hf8) << 1) + ((y & 'hf8) >> 3);
      1: cn = ((x & 'hf8) << 1) + ((x & 'hf8) >> 1) + ((y & 'hf8) >> 3);
      2: cn = ((x & 'hf8) << 1) + (x & 'hf8) + ((y & 'hf8) >> 3);
      default: cn = ((y & 'h80) << 2) + ((x & 'h80) << 1) + ((y & 'h78) << 1)
                    + ((x & 'h78) >> 3);
    endcase
    return cn * (plane_total() << 3) + (cfg.screen_base << 10) + ((y & 7) * 2);
  endfunction

  function automatic int unsigned plane_addr(int unsigned base, int unsigned n);
    return (base + ((n >> 1) << 4) + (n & 1)) % MEM_BYTES;
  endfunction

  function automatic void write_back(int e);
    int unsigned base;
    int unsigned a;
    logic [7:0] bits;
    if (line_pend[e] != 8'h00) begin
      base = row_base((line_span[e] << 3) & 'hff, (line_span[e] >> 5) & 'hff);
      for (int n = 0; n < plane_total(); n++) begin
        a = plane_addr(base, n);
        for (int i = 0; i < 8; i++) bits[i] = line_pix[e][i][n];
        if (line_pend[e] != 8'hff) bits = (bits & line_pend[e]) | (mem[a] & ~line_pend[e]);
        mem[a] = bits;
      end
      line_pend[e] = 8'h00;
    end
  endfunction

  function automatic void age_newer();
    write_back(OLDER);
    line_pix[OLDER] = line_pix[NEWER];
    line_pend[OLDER] = line_pend[NEWER];
    line_span[OLDER] = line_span[NEWER];
    line_pend[NEWER] = 8'h00;
  endfunction

  function automatic void plot_pixel(logic [7:0] x, logic [7:0] y);
    logic [7:0]  c;
    logic [12:0] span;
    int unsigned idx;
    c = color_reg;
    if (!cfg.draw_transparent) begin
      if (cfg.color_mode == 2'd3) begin
        if (cfg.freeze_high_mode ? (c[3:0] == 4'h0) : (c == 8'h00)) return;
      end else if (c[3:0] == 4'h0) begin
        return;
      end
    end
    if (cfg.dither_enable && cfg.color_mode != 2'd3) begin
      if (x[0] ^ y[0]) c = c >> 4;
      c = c & 8'h0f;
    end
    span = {y, x[7:3]};
    if (span != line_span[NEWER]) begin
      age_newer();
      line_span[NEWER] = span;
    end
    idx = x[2:0] ^ 3'd7;
    line_pix[NEWER][idx] = c;
    line_pend[NEWER][idx] = 1'b1;
    if (line_pend[NEWER] == 8'hff) age_newer();
  endfunction

  function automatic bpc_out_t predict_item(bpc_in_t it);
    bpc_out_t r;
    int unsigned base;
    r = '0;
    case (it.action)
      ACT_SET_COLOR: begin
        if (cfg.high_nibble_mode) color_reg = {color_reg[7:4], it.color_source[7:4]};
        else if (cfg.freeze_high_mode) color_reg = {color_reg[7:4], it.color_source[3:0]};
        else color_reg = it.color_source;
      end
      ACT_PLOT: plot_pixel(it.pos_x, it.pos_y);
      ACT_READ_PIXEL: begin
        write_back(OLDER);
        write_back(NEWER);
        base = row_base(it.pos_x, it.pos_y);
        for (int n = 0; n < plane_total(); n++)
          r.read_value[n] = mem[plane_addr(base, n)][it.pos_x[2:0] ^ 3'd7];
        r.read_valid = 1'b1;
      end
      ACT_FLUSH: begin
        write_back(OLDER);
        write_back(NEWER);
      end
      ACT_RAM_WRITE: mem[it.ram_address % MEM_BYTES] = it.ram_data;
      ACT_RAM_READ: begin
        r.read_value = mem[it.ram_address % MEM_BYTES];
        r.read_valid = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign results_due = due_q.size();

  always @(posedge clk) begin
    bpc_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < MEM_BYTES; i++) mem[i] = 8'h00;
      color_reg = 8'h00;
      line_pend = '{8'h00, 8'h00};
      line_span = '{13'd0, 13'd0};
      for (int i = 0; i < 8; i++) begin
        line_pix[OLDER][i] = 8'h00;
        line_pix[NEWER][i] = 8'h00;
      end
      cfg = '0;
      due_q.delete();
      fail_count <= 0;
      pixel_reads <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRAW_TRANSPARENT: cfg.draw_transparent = cfg_data[0];
          REG_DITHER_ENABLE:    cfg.dither_enable = cfg_data[0];
          REG_HIGH_NIBBLE:      cfg.high_nibble_mode = cfg_data[0];
          REG_FREEZE_HIGH:      cfg.freeze_high_mode = cfg_data[0];
          REG_OBJECT_LAYOUT:    cfg.object_layout = cfg_data[0];
          REG_COLOR_MODE:       cfg.color_mode = cfg_data[1:0];
          REG_SCREEN_HEIGHT:    cfg.screen_height = cfg_data[1:0];
          default:              cfg.screen_base = cfg_data;
        endcase
      end
      if (in_valid && !in_stall) begin
        due_q.push_back(predict_item(in_data));
        if (in_data.action == ACT_READ_PIXEL) pixel_reads <= pixel_reads + 1;
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = due_q.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10)
              $display("result mismatch: expected value %0d valid %0d, got value %0d valid %0d",
                       want.read_value, want.read_valid, out_data.read_value,
                       out_data.read_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/bitplane_pixel_plot_cache_top_tb.sv -----
`timescale 1ns / 1ps

module bitplane_pixel_plot_cache_top_tb;
  import bpc_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  bpc_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  bpc_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         results_due;
  int         pixel_reads;
  int         send_pct;
  int         recv_pct;
  int         items_sent;
  logic       long_hold_req;
  logic       long_hold_taken;
  int         hold_left;

  bitplane_pixel_plot_cache_top u_top (.*);

  bitplane_pixel_plot_cache_checker u_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      long_hold_taken <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  task automatic send_item(bpc_in_t it);
    logic taken;
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  function automatic bpc_in_t make_item(logic [2:0] act, logic [7:0] x, logic [7:0] y,
                                        logic [7:0] src, logic [16:0] addr,
                                        logic [7:0] data);
    bpc_in_t it;
    it.action = act;
    it.pos_x = x;
    it.pos_y = y;
    it.color_source = src;
    it.ram_address = addr;
    it.ram_data = data;
    return it;
  endfunction

  function automatic bpc_in_t noise_item(logic [2:0] act);
    return make_item(act, 8'($urandom), 8'($urandom), 8'($urandom), 17'($urandom),
                     8'($urandom));
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(bpc_cfg_t c);
    drain();
    write_reg(REG_DRAW_TRANSPARENT, {7'd0, c.draw_transparent});
    write_reg(REG_DITHER_ENABLE, {7'd0, c.dither_enable});
    write_reg(REG_HIGH_NIBBLE, {7'd0, c.high_nibble_mode});
    write_reg(REG_FREEZE_HIGH, {7'd0, c.freeze_high_mode});
    write_reg(REG_OBJECT_LAYOUT, {7'd0, c.object_layout});
    write_reg(REG_COLOR_MODE, {6'd0, c.color_mode});
    write_reg(REG_SCREEN_HEIGHT, {6'd0, c.screen_height});
    write_reg(REG_SCREEN_BASE, c.screen_base);
    cfg_valid <= 1'b0;
  endtask

  task automatic span_burst();
    logic [7:0] y;
    logic [7:0] xb;
    int         cnt;
    int         step;
    int         off;
    y = 8'($urandom);
    xb = 8'($urandom) & 8'hf8;
    cnt = ($urandom_range(0, 1) != 0) ? 8 : $urandom_range(1, 7);
    step = 2 * $urandom_range(0, 3) + 1;
    off = $urandom_range(0, 7);
    send_item(make_item(ACT_SET_COLOR, 0, 0, 8'($urandom), 0, 0));
    for (int i = 0; i < cnt; i++)
      send_item(make_item(ACT_PLOT, xb | 8'((i * step + off) & 7), y, 0, 0, 0));
    case ($urandom_range(0, 3))
      0: send_item(make_item(ACT_READ_PIXEL, xb | 8'($urandom_range(0, 7)), y, 0, 0, 0));
      1: send_item(make_item(ACT_FLUSH, 0, 0, 0, 0, 0));
      default: ;
    endcase
  endtask

  task automatic random_item();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: span_burst();
      5: send_item(noise_item(ACT_PLOT));
      6: send_item(noise_item(ACT_READ_PIXEL));
      7: send_item(noise_item($urandom_range(0, 1) ? ACT_RAM_WRITE : ACT_RAM_READ));
      8: send_item(noise_item(3'($urandom_range(0, 7))));
      default: send_item(noise_item(ACT_SET_COLOR));
    endcase
  endtask

  initial begin
    bpc_cfg_t setting;
    int       target;
    bit       paused;
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    long_hold_req <= 1'b0;
    send_pct = 0;
    recv_pct = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(ACT_PLOT, 8'd0, 8'd0, 0, 0, 0));
    send_item(make_item(ACT_SET_COLOR, 0, 0, 8'hff, 0, 0));
    send_item(make_item(ACT_PLOT, 8'd0, 8'd0, 0, 0, 0));
    send_item(make_item(ACT_PLOT, 8'd255, 8'd255, 0, 0, 0));
    send_item(make_item(ACT_READ_PIXEL, 8'd0, 8'd0, 0, 0, 0));
    send_item(make_item(ACT_READ_PIXEL, 8'd255, 8'd255, 0, 0, 0));
    send_item(make_item(ACT_SET_COLOR, 0, 0, 8'h5a, 0, 0));
    for (int i = 0; i < 8; i++) send_item(make_item(ACT_PLOT, 8'(16 + i), 8'd9, 0, 0, 0));
    send_item(make_item(ACT_PLOT, 8'd40, 8'd3, 0, 0, 0));
    send_item(make_item(ACT_FLUSH, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_RAM_WRITE, 0, 0, 0, 17'h1ffff, 8'hff));
    send_item(make_item(ACT_RAM_WRITE, 0, 0, 0, 17'h00000, 8'h81));
    send_item(make_item(ACT_RAM_READ, 0, 0, 0, 17'h1ffff, 0));
    send_item(make_item(ACT_RAM_READ, 0, 0, 0, 17'h00000, 0));
    send_item(make_item(3'd6, 8'hff, 8'hff, 8'hff, 17'h1ffff, 8'hff));
    send_item(make_item(3'd7, 0, 0, 0, 0, 0));

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: setting = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3, 2'd3, 8'd255};
        1: setting = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd3, 2'd2, 8'd128};
        2: setting = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1, 2'd3, 8'd0};
        3: setting = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 2'd1, 8'd127};
        8: setting = '0;
        default: setting = bpc_cfg_t'($urandom);
      endcase
      apply_setting(setting);
      send_pct = (phase < 3) ? 15 : (phase < 6) ? 66 : 0;
      recv_pct = (phase < 3) ? 66 : (phase < 6) ? 15 : 0;
      target = items_sent + 65;
      paused = 1'b0;
      while (items_sent < target) begin
        if (phase == 1 && items_sent + 50 <= target) long_hold_req <= 1'b1;
        if (phase == 4 && !paused && items_sent + 30 >= target) begin
          drain();
          paused = 1'b1;
        end
        random_item();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d items over nine register settings, %0d of them pixel reads.",
             items_sent, pixel_reads);
    $display("Idle mixes covered sender-heavy, receiver-heavy and back-to-back traffic.");
    if (fail_count == 0) begin
      $display("bitplane_pixel_plot_cache_top_tb: done, clean");
    end else begin
      $display("bitplane_pixel_plot_cache_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("bitplane_pixel_plot_cache_top_tb: done, errors");
    $finish;
  end

endmodule
